// ===== rtl/slc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package slc_pkg;

	localparam logic [7:0] CHAR_SLASH = 8'h2f;
	localparam logic [7:0] CHAR_STAR  = 8'h2a;
	localparam logic [7:0] CHAR_NL    = 8'h0a;

	typedef enum logic [1:0] {
		CLS_BLANK   = 2'd0,
		CLS_COMMENT = 2'd1,
		CLS_CODE    = 2'd2
	} line_class_t;

	// what one byte does to the current line
	typedef struct packed {
		logic        finish;
		line_class_t cls;
	} scan_result_t;

	function automatic logic is_lead_space(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0b) || (c == 8'h0c) || (c == 8'h0d);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/slc_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slc_scan (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [7:0]            char_byte,
	input  wire logic                  is_last,
	output slc_pkg::scan_result_t      res
);
	import slc_pkg::*;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_SLASH,
		PH_CODE,
		PH_COMMENT,
		PH_SCAN
	} phase_t;

	phase_t phase_q;
	logic   in_block_q;
	logic   prev_star_q;

	phase_t phase_t_d;
	logic   block_t_d;
	logic   star_t_d;
	phase_t phase_d;
	logic   block_d;
	logic   star_d;
	logic   is_nl;

	assign is_nl = (char_byte == CHAR_NL);

	// effect of taking a non-newline byte
	always_comb begin
		phase_t_d = phase_q;
		block_t_d = in_block_q;
		star_t_d  = prev_star_q;
		if (!is_nl) begin
			case (phase_q)
				PH_LEAD: begin
					if (!is_lead_space(char_byte))
						phase_t_d = (char_byte == CHAR_SLASH) ? PH_SLASH : PH_CODE;
				end
				PH_SLASH: begin
					if (char_byte == CHAR_SLASH) begin
						phase_t_d = PH_COMMENT;
					end else if (char_byte == CHAR_STAR) begin
						phase_t_d = PH_SCAN;
						block_t_d = 1'b1;
						star_t_d  = 1'b1;
					end else begin
						phase_t_d = PH_CODE;
					end
				end
				PH_SCAN: begin
					if (prev_star_q && (char_byte == CHAR_SLASH)) begin
						phase_t_d = PH_COMMENT;
						block_t_d = 1'b0;
						star_t_d  = 1'b0;
					end else begin
						star_t_d = (char_byte == CHAR_STAR);
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res.finish = is_nl || is_last;
		case (phase_t_d)
			PH_LEAD:                res.cls = CLS_BLANK;
			PH_COMMENT, PH_SCAN:    res.cls = CLS_COMMENT;
			default:                res.cls = CLS_CODE;
		endcase
	end

	always_comb begin
		if (is_last) begin
			phase_d = PH_LEAD;
			block_d = 1'b0;
			star_d  = 1'b0;
		end else if (is_nl) begin
			// a line starting inside a block is scanned for the close
			phase_d = block_t_d ? PH_SCAN : PH_LEAD;
			block_d = block_t_d;
			star_d  = 1'b0;
		end else begin
			phase_d = phase_t_d;
			block_d = block_t_d;
			star_d  = star_t_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			in_block_q  <= 1'b0;
			prev_star_q <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			in_block_q  <= block_d;
			prev_star_q <= star_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/source_line_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// an accepted byte is held in stage 1, then its line result is registered
// throughput: one byte per cycle, sustained while results are taken
// one line result per newline or final byte; other bytes give none
// reset (arst_n low, asynchronous) clears the line state, all counters and
// both valid flags; class and byte registers are left as they are
module source_line_classifier #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  char_byte,
	input  wire logic        is_last,
	output logic             line_valid,
	input  wire logic        line_ready,
	output logic [1:0]       line_class,
	output logic [31:0]      blank_lines,
	output logic [31:0]      comment_lines,
	output logic [31:0]      code_lines,
	output logic [31:0]      total_lines
);
	import slc_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   last_s1;
	logic                   advance;
	scan_result_t           scan_res;
	logic                   line_valid_q;
	line_class_t            class_q;
	logic [COUNT_WIDTH-1:0] blank_q;
	logic [COUNT_WIDTH-1:0] comment_q;
	logic [COUNT_WIDTH-1:0] code_q;
	logic [COUNT_WIDTH-1:0] total_q;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == CountMax) ? v : v + COUNT_WIDTH'(1);
	endfunction

	// counters double as the result register, so stage 2 waits for a free slot
	assign advance    = valid_s1 && (!line_valid_q || line_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			char_s1 <= char_byte;
			last_s1 <= is_last;
		end
	end

	slc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_byte (char_s1),
		.is_last   (last_s1),
		.res       (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= 1'b0;
			blank_q      <= '0;
			comment_q    <= '0;
			code_q       <= '0;
			total_q      <= '0;
		end else if (advance && scan_res.finish) begin
			line_valid_q <= 1'b1;
			total_q      <= sat_inc(total_q);
			case (scan_res.cls)
				CLS_BLANK:   blank_q   <= sat_inc(blank_q);
				CLS_COMMENT: comment_q <= sat_inc(comment_q);
				default:     code_q    <= sat_inc(code_q);
			endcase
		end else if (line_ready) begin
			line_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && scan_res.finish)
			class_q <= scan_res.cls;
	end

	assign line_valid    = line_valid_q;
	assign line_class    = 2'(class_q);
	assign blank_lines   = 32'(blank_q);
	assign comment_lines = 32'(comment_q);
	assign code_lines    = 32'(code_q);
	assign total_lines   = 32'(total_q);

endmodule
`default_nettype wire

// ===== rtl/slc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        byte_valid,
	input wire logic        byte_ready,
	input wire logic        line_valid,
	input wire logic        line_ready,
	input wire logic [1:0]  line_class,
	input wire logic [31:0] blank_lines,
	input wire logic [31:0] comment_lines,
	input wire logic [31:0] code_lines,
	input wire logic [31:0] total_lines
);

	// a stalled result keeps its request up
	a_line_hold: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && !line_ready |=> line_valid)
		else $error("line result dropped while stalled");

	a_line_stable: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && !line_ready |=> $stable(line_class) && $stable(total_lines))
		else $error("line result changed while stalled");

	// total counts every line and saturates no later than any class count, so it never falls below any of them
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid |-> (total_lines >= blank_lines) && (total_lines >= comment_lines)
			&& (total_lines >= code_lines))
		else $error("class count above total");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(line_valid && line_ready) ##1 line_valid |-> total_lines >= $past(total_lines))
		else $error("total line count went backwards");

	// nothing can come out while the input side has stayed idle and no result was pending
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(byte_valid && byte_ready) ##1 !(byte_valid && byte_ready) ##1 !$past(line_valid)
			|-> !line_valid)
		else $error("line result without a byte");

endmodule

bind source_line_classifier slc_checker u_slc_checker (.*);
`default_nettype wire
